[rtl/core/lprsd_pkg.sv]
// Shared types and constants for the white PWM and serial RGB LED driver.
package lprsd_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd5;

  localparam logic [15:0] PWM_TOP_RST    = 16'd1000;
  localparam logic [7:0]  DUTY_SCALE_RST = 8'd10;
  localparam logic [7:0]  ONE_LOW_RST    = 8'd10;
  localparam logic [7:0]  ONE_HIGH_RST   = 8'd9;
  localparam logic [7:0]  ZERO_LOW_RST   = 8'd4;
  localparam logic [7:0]  ZERO_HIGH_RST  = 8'd1;
  localparam logic [7:0]  LEVEL_RST      = 8'd2;

  localparam int COLOUR_W = 24;

  typedef struct packed {
    logic [15:0] pwm_top;
    logic [7:0]  duty_scale;
  } pwm_cfg_t;

  typedef struct packed {
    logic [7:0] one_low_ticks;
    logic [7:0] one_high_ticks;
    logic [7:0] zero_low_ticks;
    logic [7:0] zero_high_ticks;
  } ser_cfg_t;

  // One accepted word as seen by the state units.
  typedef struct packed {
    logic step;
    logic frame;
  } step_t;

endpackage

[rtl/core/lprsd_pwm.sv]
// White-channel period counter, level bytes and duty compare.
module lprsd_pwm (
  input  logic                clk,
  input  logic                rst,
  input  lprsd_pkg::step_t    ctl,
  input  lprsd_pkg::pwm_cfg_t cfg,
  input  logic [7:0]          warm_level,
  input  logic [7:0]          neutral_level,
  input  logic [7:0]          cool_level,
  output logic                warm_on_next,
  output logic                neutral_on_next,
  output logic                cool_on_next
);

  logic [15:0] period_count, period_count_next;
  logic [7:0]  warm_byte, warm_byte_next;
  logic [7:0]  neutral_byte, neutral_byte_next;
  logic [7:0]  cool_byte, cool_byte_next;
  logic [15:0] warm_duty, neutral_duty, cool_duty;

  always_comb begin
    period_count_next = period_count;
    warm_byte_next    = warm_byte;
    neutral_byte_next = neutral_byte;
    cool_byte_next    = cool_byte;
    if (ctl.step) begin
      if (ctl.frame == lprsd_pkg::OP_FRAME) begin
        warm_byte_next    = warm_level;
        neutral_byte_next = neutral_level;
        cool_byte_next    = cool_level;
      end else if (period_count >= cfg.pwm_top) begin
        period_count_next = 16'd0;
      end else begin
        period_count_next = period_count + 16'd1;
      end
    end
  end

  assign warm_duty    = 16'(warm_byte_next) * 16'(cfg.duty_scale);
  assign neutral_duty = 16'(neutral_byte_next) * 16'(cfg.duty_scale);
  assign cool_duty    = 16'(cool_byte_next) * 16'(cfg.duty_scale);

  assign warm_on_next    = period_count_next < warm_duty;
  assign neutral_on_next = period_count_next < neutral_duty;
  assign cool_on_next    = period_count_next < cool_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= 16'd0;
      warm_byte    <= lprsd_pkg::LEVEL_RST;
      neutral_byte <= lprsd_pkg::LEVEL_RST;
      cool_byte    <= lprsd_pkg::LEVEL_RST;
    end else begin
      period_count <= period_count_next;
      warm_byte    <= warm_byte_next;
      neutral_byte <= neutral_byte_next;
      cool_byte    <= cool_byte_next;
    end
  end

endmodule

[rtl/core/lprsd_ser.sv]
// Serial RGB transmitter: stored colour, bit shifter and phase timer.
module lprsd_ser #(
  parameter int COLOUR_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lprsd_pkg::step_t         ctl,
  input  lprsd_pkg::ser_cfg_t      cfg,
  input  logic [lprsd_pkg::COLOUR_W-1:0] colour,
  output logic                     line_next,
  output logic                     busy_next
);

  localparam int BW = $clog2(COLOUR_BITS + 1);

  logic [lprsd_pkg::COLOUR_W-1:0] stored_colour, stored_colour_next;
  logic [COLOUR_BITS-1:0]         bit_shifter, bit_shifter_next;
  logic [BW-1:0]                  bits_left, bits_left_next;
  logic [7:0]                     phase_ticks, phase_ticks_next;
  logic                           in_high_phase, in_high_phase_next;
  logic                           colour_pending, colour_pending_next;
  logic [7:0]                     ticks_dec;
  logic                           start;

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  always_comb begin
    stored_colour_next  = stored_colour;
    bit_shifter_next    = bit_shifter;
    bits_left_next      = bits_left;
    phase_ticks_next    = phase_ticks;
    in_high_phase_next  = in_high_phase;
    colour_pending_next = colour_pending;
    start               = 1'b0;
    ticks_dec           = (phase_ticks != 8'd0) ? phase_ticks - 8'd1 : 8'd0;
    if (ctl.step) begin
      if (ctl.frame == lprsd_pkg::OP_FRAME) begin
        if (colour != stored_colour) begin
          stored_colour_next = colour;
          if (bits_left == '0) begin
            start = 1'b1;
          end else begin
            colour_pending_next = 1'b1;
          end
        end
      end else if (bits_left != '0) begin
        phase_ticks_next = ticks_dec;
        if (ticks_dec == 8'd0) begin
          if (!in_high_phase) begin
            in_high_phase_next = 1'b1;
            phase_ticks_next = bit_shifter[COLOUR_BITS-1] ? at_least_one(cfg.one_high_ticks)
                                                         : at_least_one(cfg.zero_high_ticks);
          end else if (bits_left != BW'(1)) begin
            // advance to the next bit, low phase first
            bits_left_next     = bits_left - BW'(1);
            bit_shifter_next   = bit_shifter << 1;
            in_high_phase_next = 1'b0;
            phase_ticks_next = bit_shifter[COLOUR_BITS-2] ? at_least_one(cfg.one_low_ticks)
                                                         : at_least_one(cfg.zero_low_ticks);
          end else begin
            bits_left_next     = '0;
            bit_shifter_next   = '0;
            in_high_phase_next = 1'b0;
            phase_ticks_next   = 8'd0;
            start              = colour_pending;
          end
        end
      end
    end
    if (start) begin
      // colour fills the top of the word, padding bits go out as zeros
      bit_shifter_next    = COLOUR_BITS'(stored_colour_next) << (COLOUR_BITS - lprsd_pkg::COLOUR_W);
      bits_left_next      = BW'(COLOUR_BITS);
      colour_pending_next = 1'b0;
      in_high_phase_next  = 1'b0;
      phase_ticks_next = stored_colour_next[lprsd_pkg::COLOUR_W-1]
                         ? at_least_one(cfg.one_low_ticks) : at_least_one(cfg.zero_low_ticks);
    end
  end

  assign busy_next = bits_left_next != '0;
  assign line_next = busy_next ? in_high_phase_next : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_colour  <= '0;
      bit_shifter    <= '0;
      bits_left      <= '0;
      phase_ticks    <= 8'd0;
      in_high_phase  <= 1'b0;
      colour_pending <= 1'b0;
    end else begin
      stored_colour  <= stored_colour_next;
      bit_shifter    <= bit_shifter_next;
      bits_left      <= bits_left_next;
      phase_ticks    <= phase_ticks_next;
      in_high_phase  <= in_high_phase_next;
      colour_pending <= colour_pending_next;
    end
  end

endmodule

[rtl/core/led_pwm_and_rgb_serial_driver_top.sv]
// Top level: config registers, input handshake, state units and result register.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[15:0]
//  in      | in_valid / in_ready   | opcode, warm/neutral/cool_level, red/green/blue_in
//  out     | out_valid / out_ready | warm_on, neutral_on, cool_on, serial_line, serial_busy
//
// One word a cycle while the result is not stalled: each accepted word updates the PWM and
// serial state in the same cycle and its result lands in the output register on that edge.
// A new word is taken while the held result is being taken; a stalled result stops input.
// Config writes are taken whenever out of reset. Synchronous reset restores register
// defaults and holds both ready outputs low.
module led_pwm_and_rgb_serial_driver_top #(
  parameter int COLOUR_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lprsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lprsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [7:0]                          warm_level,
  input  logic [7:0]                          neutral_level,
  input  logic [7:0]                          cool_level,
  input  logic [7:0]                          red_in,
  input  logic [7:0]                          green_in,
  input  logic [7:0]                          blue_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                warm_on,
  output logic                                neutral_on,
  output logic                                cool_on,
  output logic                                serial_line,
  output logic                                serial_busy
);

  lprsd_pkg::pwm_cfg_t pwm_cfg;
  lprsd_pkg::ser_cfg_t ser_cfg;
  lprsd_pkg::step_t    ctl;
  logic warm_on_next, neutral_on_next, cool_on_next, line_next, busy_next;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (!out_valid || out_ready);
  assign ctl.step  = in_valid && in_ready;
  assign ctl.frame = opcode;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_cfg.pwm_top         <= lprsd_pkg::PWM_TOP_RST;
      pwm_cfg.duty_scale      <= lprsd_pkg::DUTY_SCALE_RST;
      ser_cfg.one_low_ticks   <= lprsd_pkg::ONE_LOW_RST;
      ser_cfg.one_high_ticks  <= lprsd_pkg::ONE_HIGH_RST;
      ser_cfg.zero_low_ticks  <= lprsd_pkg::ZERO_LOW_RST;
      ser_cfg.zero_high_ticks <= lprsd_pkg::ZERO_HIGH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lprsd_pkg::REG_PWM_TOP:    pwm_cfg.pwm_top         <= cfg_data;
        lprsd_pkg::REG_DUTY_SCALE: pwm_cfg.duty_scale      <= cfg_data[7:0];
        lprsd_pkg::REG_ONE_LOW:    ser_cfg.one_low_ticks   <= cfg_data[7:0];
        lprsd_pkg::REG_ONE_HIGH:   ser_cfg.one_high_ticks  <= cfg_data[7:0];
        lprsd_pkg::REG_ZERO_LOW:   ser_cfg.zero_low_ticks  <= cfg_data[7:0];
        lprsd_pkg::REG_ZERO_HIGH:  ser_cfg.zero_high_ticks <= cfg_data[7:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  lprsd_pwm u_pwm (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .cfg             (pwm_cfg),
    .warm_level      (warm_level),
    .neutral_level   (neutral_level),
    .cool_level      (cool_level),
    .warm_on_next    (warm_on_next),
    .neutral_on_next (neutral_on_next),
    .cool_on_next    (cool_on_next)
  );

  lprsd_ser #(
    .COLOUR_BITS (COLOUR_BITS)
  ) u_ser (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (ser_cfg),
    .colour    ({red_in, green_in, blue_in}),
    .line_next (line_next),
    .busy_next (busy_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      warm_on     <= warm_on_next;
      neutral_on  <= neutral_on_next;
      cool_on     <= cool_on_next;
      serial_line <= line_next;
      serial_busy <= busy_next;
    end
  end

endmodule

[tb/sv/lamp_drive_checker.sv]
// Checker for the white PWM and serial RGB LED driver: predicts each result and compares it.
module lamp_drive_checker
  import lprsd_pkg::*;
#(
  parameter int COLOUR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  warm_level,
  input  logic [7:0]  neutral_level,
  input  logic [7:0]  cool_level,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        warm_on,
  input  logic        neutral_on,
  input  logic        cool_on,
  input  logic        serial_line,
  input  logic        serial_busy,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic warm;
    logic neutral;
    logic cool;
    logic line;
    logic busy;
  } lamp_out_t;

  // register copies
  logic [15:0] pwm_top_q;
  logic [7:0]  scale_q;
  logic [7:0]  one_lo_q;
  logic [7:0]  one_hi_q;
  logic [7:0]  zero_lo_q;
  logic [7:0]  zero_hi_q;

  // lamp state
  logic [15:0]            period_q;
  logic [7:0]             warm_q;
  logic [7:0]             neutral_q;
  logic [7:0]             cool_q;
  logic [23:0]            colour_q;
  logic [COLOUR_BITS-1:0] shift_q;
  int                     bits_q;
  logic [7:0]             phase_q;
  logic                   high_q;
  logic                   colour_held_q;

  lamp_out_t due_outputs[$];
  lamp_out_t want;

  initial errors = 0;

  task automatic flag(input string msg);
    $display("%0t lamp check: %s", $time, msg);
    errors++;
  endtask

  task automatic check_bit(input string name, input logic got, input logic exp_val);
    if (got !== exp_val) flag($sformatf("%s got %b, predicted %b", name, got, exp_val));
  endtask

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [15:0] duty_of(input logic [7:0] lvl);
    return 16'(lvl) * 16'(scale_q);
  endfunction

  function automatic void load_low_phase();
    high_q = 1'b0;
    phase_q = shift_q[COLOUR_BITS-1] ? at_least_one(one_lo_q) : at_least_one(zero_lo_q);
  endfunction

  function automatic void start_colour_send();
    // colour sits in the top bits, any extra low bits go out as zeros
    shift_q = '0;
    shift_q[COLOUR_BITS-1 -: 24] = colour_q;
    bits_q = COLOUR_BITS;
    colour_held_q = 1'b0;
    load_low_phase();
  endfunction

  function automatic void advance_serial();
    if (bits_q == 0) return;
    if (phase_q != 8'd0) phase_q = phase_q - 8'd1;
    if (phase_q != 8'd0) return;
    if (!high_q) begin
      high_q = 1'b1;
      phase_q = shift_q[COLOUR_BITS-1] ? at_least_one(one_hi_q) : at_least_one(zero_hi_q);
      return;
    end
    bits_q--;
    if (bits_q != 0) begin
      shift_q = shift_q << 1;
      load_low_phase();
      return;
    end
    shift_q = '0;
    high_q = 1'b0;
    phase_q = 8'd0;
    if (colour_held_q) start_colour_send();
  endfunction

  function automatic lamp_out_t predict_lamp_outputs(input logic op, input logic [7:0] w,
                                                     input logic [7:0] n, input logic [7:0] c,
                                                     input logic [23:0] rgb);
    lamp_out_t res;
    if (op == OP_TICK) begin
      if (period_q >= pwm_top_q) period_q = 16'd0;
      else period_q = period_q + 16'd1;
      advance_serial();
    end else begin
      warm_q = w;
      neutral_q = n;
      cool_q = c;
      if (rgb != colour_q) begin
        colour_q = rgb;
        if (bits_q == 0) start_colour_send();
        else colour_held_q = 1'b1;
      end
    end
    res.warm = period_q < duty_of(warm_q);
    res.neutral = period_q < duty_of(neutral_q);
    res.cool = period_q < duty_of(cool_q);
    res.busy = bits_q != 0;
    res.line = res.busy ? high_q : 1'b1;
    return res;
  endfunction

  function automatic void write_register(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_PWM_TOP:    pwm_top_q = data;
      REG_DUTY_SCALE: scale_q = data[7:0];
      REG_ONE_LOW:    one_lo_q = data[7:0];
      REG_ONE_HIGH:   one_hi_q = data[7:0];
      REG_ZERO_LOW:   zero_lo_q = data[7:0];
      REG_ZERO_HIGH:  zero_hi_q = data[7:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pwm_top_q = PWM_TOP_RST;
      scale_q = DUTY_SCALE_RST;
      one_lo_q = ONE_LOW_RST;
      one_hi_q = ONE_HIGH_RST;
      zero_lo_q = ZERO_LOW_RST;
      zero_hi_q = ZERO_HIGH_RST;
      period_q = 16'd0;
      warm_q = LEVEL_RST;
      neutral_q = LEVEL_RST;
      cool_q = LEVEL_RST;
      colour_q = 24'd0;
      shift_q = '0;
      bits_q = 0;
      phase_q = 8'd0;
      high_q = 1'b0;
      colour_held_q = 1'b0;
      due_outputs.delete();
    end else begin
      // retire the oldest prediction before queuing a new one
      if (out_valid && out_ready) begin
        if (due_outputs.size() == 0) begin
          flag("result word with no prediction waiting");
        end else begin
          want = due_outputs.pop_front();
          check_bit("warm_on", warm_on, want.warm);
          check_bit("neutral_on", neutral_on, want.neutral);
          check_bit("cool_on", cool_on, want.cool);
          check_bit("serial_line", serial_line, want.line);
          check_bit("serial_busy", serial_busy, want.busy);
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready)
        due_outputs.push_back(predict_lamp_outputs(opcode, warm_level, neutral_level,
                                                   cool_level, {red_in, green_in, blue_in}));
    end
    pending = due_outputs.size();
  end

endmodule

[tb/sv/testbench.sv]
// Stimulus and verdict for the white PWM and serial RGB LED driver.
module testbench;
  import lprsd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int PHASES = 7;
  localparam int WORDS_PER_PHASE = 130;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [7:0]  warm_level;
  logic [7:0]  neutral_level;
  logic [7:0]  cool_level;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        warm_on;
  logic        neutral_on;
  logic        cool_on;
  logic        serial_line;
  logic        serial_busy;
  int          errors;
  int          pending;

  int idle_plan [4] = '{0, 75, 0, 29};
  int stall_plan [4] = '{0, 0, 75, 29};
  int idle_pct = 0;
  int stall_pct = 0;
  logic [23:0] last_colour;

  always #5 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  led_pwm_and_rgb_serial_driver_top dut (.*);

  lamp_drive_checker watch (.*);

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic push_word(input logic op, input logic [7:0] w, input logic [7:0] n,
                           input logic [7:0] c, input logic [23:0] rgb);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    warm_level <= w;
    neutral_level <= n;
    cool_level <= c;
    {red_in, green_in, blue_in} <= rgb;
    // hold the word until the handshake completes
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic random_word();
    logic [23:0] rgb;
    if ($urandom_range(99) < 12) begin
      rgb = ($urandom_range(99) < 35) ? last_colour : 24'($urandom);
      last_colour = rgb;
      push_word(OP_FRAME, pick_level(), pick_level(), pick_level(), rgb);
    end else begin
      // ticks carry junk payload that must be ignored
      push_word(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] top_v;
    logic [15:0] scale_v;
    logic [15:0] one_lo_v;
    logic [15:0] one_hi_v;
    logic [15:0] zero_lo_v;
    logic [15:0] zero_hi_v;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_TICK;
    warm_level = '0;
    neutral_level = '0;
    cool_level = '0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    last_colour = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: level extremes, unchanged colour, send start, held and replaced colours
    push_word(OP_TICK, 8'h00, 8'h00, 8'h00, 24'h000000);
    push_word(OP_FRAME, 8'h00, 8'h00, 8'h00, 24'h000000);
    push_word(OP_FRAME, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
    repeat (3) push_word(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
    push_word(OP_FRAME, 8'h01, 8'h80, 8'hFE, 24'h000000);
    push_word(OP_FRAME, 8'h80, 8'h7F, 8'h01, 24'h123456);
    push_word(OP_FRAME, 8'h02, 8'h02, 8'h02, 24'h123456);
    repeat (6) push_word(OP_TICK, 8'h00, 8'h00, 8'h00, 24'h000000);
    push_word(OP_FRAME, 8'hFF, 8'h00, 8'hFF, 24'hA5005A);
    repeat (4) push_word(OP_TICK, 8'h55, 8'hAA, 8'h55, 24'hAAAAAA);
    last_colour = 24'hA5005A;

    for (int p = 0; p < PHASES; p++) begin
      idle_pct = idle_plan[p % 4];
      stall_pct = stall_plan[p % 4];
      if (p > 0) begin
        wait_drained();
        case (p)
          1: begin
            top_v = 16'hFFFF;
            scale_v = 16'hFFFF;
            one_lo_v = 16'hFFFF;
            one_hi_v = 16'hFFFF;
            zero_lo_v = 16'hFFFF;
            zero_hi_v = 16'hFFFF;
          end
          2: begin
            top_v = 16'd1;
            scale_v = 16'd1;
            one_lo_v = 16'd1;
            one_hi_v = 16'd1;
            zero_lo_v = 16'd1;
            zero_hi_v = 16'd1;
          end
          3: begin
            // zero period top, zero scale and zero phase lengths; upper bits are dropped
            top_v = 16'h0000;
            scale_v = 16'hA500;
            one_lo_v = 16'hFF00;
            one_hi_v = 16'h3C00;
            zero_lo_v = 16'h0100;
            zero_hi_v = 16'hFF00;
          end
          default: begin
            top_v = (p == PHASES - 1) ? 16'($urandom_range(100, 2000))
                                      : 16'($urandom_range(2, 40));
            scale_v = {8'($urandom), (p == PHASES - 1) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(1, 20))};
            one_lo_v = {8'($urandom), 8'($urandom_range(1, 3))};
            one_hi_v = {8'($urandom), 8'($urandom_range(1, 3))};
            zero_lo_v = {8'($urandom), 8'($urandom_range(1, 3))};
            zero_hi_v = {8'($urandom), 8'($urandom_range(1, 3))};
          end
        endcase
        cfg_write(REG_PWM_TOP, top_v);
        cfg_write(REG_DUTY_SCALE, scale_v);
        cfg_write(REG_ONE_LOW, one_lo_v);
        cfg_write(REG_ONE_HIGH, one_hi_v);
        cfg_write(REG_ZERO_LOW, zero_lo_v);
        cfg_write(REG_ZERO_HIGH, zero_hi_v);
        if (p == 1) begin
          cfg_write(REG_SPARE_A, 16'($urandom));
          cfg_write(REG_SPARE_B, 16'($urandom));
        end
        cfg_valid <= 1'b0;
      end
      repeat (WORDS_PER_PHASE) random_word();
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
